// ===== design/crc16at_pkg.sv =====
// Shared types, constants and functions for the CRC-16 ASCII trailer generator/checker.
// Has no dependencies. Every design file imports it.
`timescale 1ns / 1ps

package crc16at_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0101;
  localparam logic [7:0]  LETTER_A = 8'h41;
  localparam logic [2:0]  WIN_FULL = 3'd4;

  typedef enum logic {
    MODE_GEN   = 1'b0,
    MODE_CHECK = 1'b1
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic [31:0] trailer_chars;
    logic        check_ok;
    logic        too_short;
  } out_item_t;

  // handshake between input register, core and result register
  typedef struct packed {
    logic fire;
    logic emit;
  } step_ctrl_t;

  // msb-first byte update, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] nibble_letter(input logic [3:0] n);
    return {4'h0, n} + LETTER_A;
  endfunction

  // high letter keeps its low nibble, low letter wraps over all eight bits
  function automatic logic [7:0] letter_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] dh;
    logic [7:0] dl;
    dh = hi - LETTER_A;
    dl = lo - LETTER_A;
    return {dh[3:0], 4'h0} | dl;
  endfunction

endpackage

// ===== design/crc16_ascii_trailer_gen_check.sv =====
// Top level of the CRC-16 ASCII trailer generator/checker.
// Depends on crc16at_pkg, crc16at_in_reg, crc16at_core and crc16at_out_reg.
`timescale 1ns / 1ps

// Takes one message byte per clock and keeps a running msb-first CRC-16 (poly 0x1021,
// start value 0x0101). In generate mode the item flagged last yields the CRC and its
// four-letter trailer ('A' plus each nibble, high nibble first). In check mode the
// newest four bytes are held back as the received trailer and only older bytes enter
// the CRC; the last item yields the CRC, the received trailer, a match flag and a flag
// for messages of fewer than four bytes. The block sustains one item per cycle: each
// byte passes an input register, one byte-wide CRC update and a result register. Only
// a last byte can stall, and only while the result register still holds a result not
// yet taken. Writing cfg_wdata (0 generate, 1 check) with cfg_we re-arms the message
// state and must happen while no item is in flight.
module crc16_ascii_trailer_gen_check
  import crc16at_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       out_free;
  logic       s1_valid;
  in_item_t   s1_item;
  step_ctrl_t ctrl;
  out_item_t  result;

  assign ctrl.fire = s1_valid && (!s1_item.last_byte || out_free);
  assign ctrl.emit = s1_valid && s1_item.last_byte && out_free;

  crc16at_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  crc16at_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .item      (s1_item),
    .result    (result)
  );

  crc16at_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_item.last_byte) |-> in_ready)
    else $error("non-final item blocked the input");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> ctrl.fire)
    else $error("result without a consumed item");

endmodule

// ===== design/crc16at_in_reg.sv =====
// Input register stage: one item per cycle unless stalled, held until the core takes it.
// Stalls while a held last byte waits for the result register. Depends on crc16at_pkg.
`timescale 1ns / 1ps

module crc16at_in_reg
  import crc16at_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     out_free,
  output logic     s1_valid,
  output in_item_t s1_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     move;
  logic     load;

  // an item that yields no result never needs the result register
  assign move     = valid_r && (!item_r.last_byte || out_free);
  assign in_ready = !valid_r || move;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (move) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== design/crc16at_core.sv =====
// Message state (mode, crc, trailer window, byte count) and the per-item result logic.
// Depends on crc16at_pkg.
`timescale 1ns / 1ps

module crc16at_core
  import crc16at_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  step_ctrl_t ctrl,
  input  in_item_t   item,
  output out_item_t  result
);

  mode_t       mode_r;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [7:0]  win_r   [4];
  logic [7:0]  win_nxt [4];
  logic [2:0]  seen_r;
  logic [2:0]  seen_nxt;

  logic [15:0] crc_upd;
  logic [7:0]  win_sh  [4];
  logic [2:0]  seen_inc;
  logic        short_msg;
  logic [15:0] decoded;

  always_comb begin
    crc_upd   = crc_r;
    win_sh[0] = win_r[1];
    win_sh[1] = win_r[2];
    win_sh[2] = win_r[3];
    win_sh[3] = item.data_byte;
    seen_inc  = (seen_r < WIN_FULL) ? seen_r + 3'd1 : seen_r;
    short_msg = 1'b0;
    decoded   = {letter_pair(win_sh[0], win_sh[1]), letter_pair(win_sh[2], win_sh[3])};
    result    = '0;

    unique case (mode_r)
      MODE_GEN: begin
        crc_upd                = crc_byte(crc_r, item.data_byte);
        result.crc_value       = crc_upd;
        result.trailer_chars   = {nibble_letter(crc_upd[15:12]), nibble_letter(crc_upd[11:8]),
                                  nibble_letter(crc_upd[7:4]), nibble_letter(crc_upd[3:0])};
      end
      MODE_CHECK: begin
        // the oldest window byte leaves the trailer and joins the body
        if (seen_r >= WIN_FULL) begin
          crc_upd = crc_byte(crc_r, win_r[0]);
        end
        short_msg        = seen_inc < WIN_FULL;
        result.crc_value = crc_upd;
        result.too_short = short_msg;
        if (!short_msg) begin
          result.trailer_chars = {win_sh[0], win_sh[1], win_sh[2], win_sh[3]};
          result.check_ok      = decoded == crc_upd;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    crc_nxt  = crc_r;
    win_nxt  = win_r;
    seen_nxt = seen_r;
    priority if (cfg_we || (ctrl.fire && item.last_byte)) begin
      crc_nxt  = CRC_INIT;
      win_nxt  = '{default: 8'h00};
      seen_nxt = 3'd0;
    end else if (ctrl.fire) begin
      crc_nxt = crc_upd;
      if (mode_r == MODE_CHECK) begin
        win_nxt  = win_sh;
        seen_nxt = seen_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GEN;
      crc_r  <= CRC_INIT;
      win_r  <= '{default: 8'h00};
      seen_r <= 3'd0;
    end else begin
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_wdata);
      end
      crc_r  <= crc_nxt;
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
    end
  end

  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= WIN_FULL)
    else $error("byte count past saturation");

  a_gen_idle_window: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_GEN) |-> (seen_r == 3'd0))
    else $error("window count moved in generate mode");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fire && item.last_byte) |=> (crc_r == CRC_INIT && seen_r == 3'd0))
    else $error("message state not re-armed after last byte");

  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> (ctrl.fire && item.last_byte))
    else $error("result emitted for a non-final byte");

endmodule

// ===== design/crc16at_out_reg.sv =====
// Result register: holds one finished result until the consumer takes it.
// Depends on crc16at_pkg.
`timescale 1ns / 1ps

module crc16at_out_reg
  import crc16at_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  step_ctrl_t ctrl,
  input  out_item_t  result,
  output logic       out_free,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> out_free)
    else $error("result register overwritten before it was taken");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> valid_r)
    else $error("emitted result not presented");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready && !ctrl.emit) |=> (valid_r && $stable(data_r)))
    else $error("waiting result changed");

endmodule

// ===== tb/tb_crc16_ascii_trailer_gen_check.sv =====
// Testbench for crc16_ascii_trailer_gen_check: random and directed byte messages in both modes,
// results checked against an in-bench CRC-16 trailer predictor.
// Depends on crc16at_pkg and the design top level only.
`timescale 1ns / 1ps

module tb_crc16_ascii_trailer_gen_check;
  import crc16at_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned ITEM_TARGET = 850;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  crc16_ascii_trailer_gen_check i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // stimulus and expectation stores
  in_item_t    byte_queue[$];
  logic [7:0]  msg_bytes[$];
  out_item_t   expected_frames[$];
  bit          no_idle = 1'b0;

  // predictor copy of the block state
  mode_t       pred_mode = MODE_GEN;
  logic [15:0] pred_crc = CRC_INIT;
  logic [31:0] pred_window = '0;
  int unsigned pred_seen = 0;

  int unsigned err_cnt = 0;
  int unsigned n_queued = 0;
  int unsigned n_msgs = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_matches = 0;
  int unsigned n_short = 0;
  int unsigned n_cfg = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  out_item_t   want;

  // bit-serial form of the byte update
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [31:0] trailer_for(input logic [15:0] crc);
    logic [31:0] t;
    for (int n = 0; n < 4; n++) begin
      t[8*n +: 8] = LETTER_A + {4'h0, crc[4*n +: 4]};
    end
    return t;
  endfunction

  // high letter of a pair keeps its low nibble, low letter wraps over all eight bits
  function automatic logic [15:0] decode_letters(input logic [31:0] w);
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    d0 = w[31:24] - LETTER_A;
    d1 = w[23:16] - LETTER_A;
    d2 = w[15:8] - LETTER_A;
    d3 = w[7:0] - LETTER_A;
    return {({d0[3:0], 4'h0} | d1), ({d2[3:0], 4'h0} | d3)};
  endfunction

  function automatic logic [15:0] crc_over_msg();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (msg_bytes[i]) c = crc_next(c, msg_bytes[i]);
    return c;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic rearm_pred();
    pred_crc = CRC_INIT;
    pred_window = '0;
    pred_seen = 0;
  endtask

  task automatic predict_frame(input in_item_t it);
    out_item_t r;
    r = '0;
    if (pred_mode == MODE_GEN) begin
      pred_crc = crc_next(pred_crc, it.data_byte);
      r.crc_value = pred_crc;
      r.trailer_chars = trailer_for(pred_crc);
    end else begin
      // only bytes leaving the four-byte window reach the crc
      if (pred_seen == 4) pred_crc = crc_next(pred_crc, pred_window[31:24]);
      pred_window = {pred_window[23:0], it.data_byte};
      if (pred_seen < 4) pred_seen++;
      r.crc_value = pred_crc;
      if (pred_seen < 4) begin
        r.too_short = 1'b1;
      end else begin
        r.trailer_chars = pred_window;
        r.check_ok = (decode_letters(pred_window) == pred_crc);
      end
    end
    if (it.last_byte) begin
      expected_frames.push_back(r);
      rearm_pred();
    end
  endtask

  task automatic append_trailer(input logic [31:0] t);
    for (int n = 3; n >= 0; n--) msg_bytes.push_back(t[8*n +: 8]);
  endtask

  task automatic flush_msg(input bit close);
    in_item_t it;
    foreach (msg_bytes[i]) begin
      it.data_byte = msg_bytes[i];
      it.last_byte = close && (i == msg_bytes.size() - 1);
      byte_queue.push_back(it);
    end
    n_queued += msg_bytes.size();
    if (close) n_msgs++;
    msg_bytes.delete();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_frames.size() != 0) @(negedge clk);
    // non-last bytes leave no result behind, so let the pipeline drain
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0 && !no_idle) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (byte_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= byte_queue.pop_front();
        in_gap <= no_idle ? 0 : gap_len();
      end else begin
        in_valid <= 1'b0;
        in_gap <= 0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      pred_mode = MODE_GEN;
      rearm_pred();
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("result with no item expected: %h", out_data);
          err_cnt++;
        end else begin
          want = expected_frames.pop_front();
          if (out_data.crc_value !== want.crc_value) begin
            $error("crc_value: expected %h, actual %h", want.crc_value, out_data.crc_value);
            err_cnt++;
          end
          if (out_data.trailer_chars !== want.trailer_chars) begin
            $error("trailer_chars: expected %h, actual %h", want.trailer_chars,
                   out_data.trailer_chars);
            err_cnt++;
          end
          if (out_data.check_ok !== want.check_ok) begin
            $error("check_ok: expected %b, actual %b", want.check_ok, out_data.check_ok);
            err_cnt++;
          end
          if (out_data.too_short !== want.too_short) begin
            $error("too_short: expected %b, actual %b", want.too_short, out_data.too_short);
            err_cnt++;
          end
        end
        n_results++;
        if (out_data.check_ok === 1'b1) n_matches++;
        if (out_data.too_short === 1'b1) n_short++;
      end
      if (cfg_we) begin
        pred_mode = mode_t'(cfg_wdata);
        rearm_pred();
      end
      if (in_valid && in_ready) begin
        n_accepted++;
        predict_frame(in_data);
      end
      if (no_idle) begin
        out_ready <= 1'b1;
        out_stall <= 0;
      end else if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mode_t       m;
    int unsigned nm;
    int unsigned len;
    int unsigned kind;
    int unsigned pos;
    logic [3:0]  k;
    logic [31:0] t;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // generate mode straight after reset
    msg_bytes.push_back(8'h00);
    flush_msg(1'b1);
    msg_bytes.push_back(8'hff);
    flush_msg(1'b1);
    msg_bytes.push_back(8'ha5);
    msg_bytes.push_back(8'h5a);
    flush_msg(1'b1);

    wait_idle();
    write_mode(MODE_CHECK);
    // short messages: one byte and three bytes
    msg_bytes.push_back(8'h00);
    flush_msg(1'b1);
    msg_bytes.push_back(8'h41);
    msg_bytes.push_back(8'h42);
    msg_bytes.push_back(8'h43);
    flush_msg(1'b1);
    // trailer only, empty body
    append_trailer(trailer_for(CRC_INIT));
    flush_msg(1'b1);
    // 'Q' in the high letter wraps onto 'A'
    append_trailer(32'h5142_4142);
    flush_msg(1'b1);
    msg_bytes.push_back(8'hff);
    t = trailer_for(crc_over_msg());
    append_trailer(t);
    flush_msg(1'b1);
    // non-letter trailer bytes
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hff);
    msg_bytes.push_back(8'h7f);
    msg_bytes.push_back(8'h80);
    flush_msg(1'b1);
    // mode change in the middle of a message
    msg_bytes.push_back(8'h10);
    msg_bytes.push_back(8'h20);
    flush_msg(1'b0);
    wait_idle();
    write_mode(MODE_GEN);
    msg_bytes.push_back(8'h7e);
    flush_msg(1'b1);

    while (n_queued < ITEM_TARGET) begin
      m = mode_t'($urandom_range(0, 1));
      wait_idle();
      no_idle = ($urandom_range(0, 4) == 0);
      write_mode(m);
      nm = $urandom_range(3, 12);
      repeat (nm) begin
        if (m == MODE_GEN) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
          repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          kind = $urandom_range(0, 99);
          if (kind < 82) begin
            len = $urandom_range(0, 10);
            repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
            t = trailer_for(crc_over_msg());
            if (kind >= 70) begin
              // alias the first high letter outside A..P, the second one possibly too, still a match
              k = 4'($urandom_range(1, 15));
              t[31:24] = t[31:24] + {k, 4'h0};
              k = 4'($urandom_range(0, 15));
              t[15:8] = t[15:8] + {k, 4'h0};
            end else if (kind >= 60) begin
              pos = $urandom_range(0, 3);
              t[8*pos +: 8] = t[8*pos +: 8] ^ 8'($urandom_range(1, 255));
            end
            append_trailer(t);
          end else begin
            len = (kind < 92) ? $urandom_range(1, 12) : $urandom_range(1, 3);
            repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        flush_msg(1'b1);
      end
      // sometimes leave a message open across the next mode write
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 6);
        repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
        flush_msg(1'b0);
      end
    end

    wait_idle();
    $display("%0d bytes in %0d closed messages over %0d mode writes", n_accepted, n_msgs,
             n_cfg);
    $display("%0d results checked: %0d trailer matches, %0d short messages", n_results,
             n_matches, n_short);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
